// ===== hw/rtl/cnnacc_pkg.sv =====
package cnnacc_pkg;

   localparam int SAMPLE_W = 32;
   localparam int NLL_W    = 48;
   localparam int CSR_IDX_W = 2;
   localparam int TABLE_W  = 22;
   localparam int TERM_W   = 50;
   localparam int Q_W      = 41;
   localparam int MAG_W    = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_CENSOR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_SIGMA   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SIGMA   = 2'd3;

   localparam logic [1:0] MODE_LOWER = 2'd0;
   localparam logic [1:0] MODE_UPPER = 2'd1;
   localparam logic [1:0] MODE_BOTH  = 2'd2;

   localparam logic [31:0]    INV_SIGMA_RESET = 32'h0100_0000;
   localparam logic [Q_W-1:0] EIGHT_Q16       = 41'd524288;
   localparam logic [15:0]    HALF_LOG_2PI    = 16'd60224;
   localparam logic [15:0]    LN2_Q16         = 16'd45426;
   localparam logic [4:0]     LN_BIAS         = 5'd16;
   localparam logic [4:0]     LN_TOP          = 5'd31;
   localparam logic [4:0]     DIV_STEPS       = 5'd11;
   localparam logic [4:0]     LN_STEPS        = 5'd16;

   localparam logic signed [NLL_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [NLL_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

   typedef enum logic [1:0] {KIND_UNC, KIND_LOWER, KIND_UPPER} kind_type;

   typedef enum logic [2:0] {PATH_UNC, PATH_ZERO, PATH_TABLE, PATH_TAIL, PATH_SAT} path_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_FILL, OP_LOAD, OP_DIFF, OP_ABS, OP_MUL0, OP_MUL1, OP_SQ, OP_UNC,
      OP_TIDX, OP_RD0, OP_RD1, OP_CAP1, OP_TINT, OP_DIV, OP_LNNORM, OP_LNSQ,
      OP_LNMUL, OP_TAIL, OP_ACC, OP_SAT, OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      ST_FILL, ST_IDLE, ST_DIFF, ST_ABS, ST_MUL0, ST_MUL1, ST_ROUTE, ST_SQ, ST_UNC,
      ST_TIDX, ST_RD0, ST_RD1, ST_CAP1, ST_TINT, ST_DIV, ST_LNNORM, ST_LNSQ,
      ST_LNMUL, ST_TAIL, ST_ACC, ST_SAT, ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic     skip;
      logic     last;
      path_type path;
      logic     ln_norm;
      logic     fill_last;
   } stat_type;

   // -log Phi at -8, -7.5, ... 8, Q.16
   function automatic logic [TABLE_W-1:0] phi_anchor(input logic [5:0] k);
      logic [TABLE_W-1:0] v;
      unique case (k)
         6'd0:  v = 22'd2294641;
         6'd1:  v = 22'd2036590;
         6'd2:  v = 22'd1794658;
         6'd3:  v = 22'd1568811;
         6'd4:  v = 22'd1359005;
         6'd5:  v = 22'd1165189;
         6'd6:  v = 22'd987300;
         6'd7:  v = 22'd825257;
         6'd8:  v = 22'd678960;
         6'd9:  v = 22'd548278;
         6'd10: v = 22'd433044;
         6'd11: v = 22'd333031;
         6'd12: v = 22'd247935;
         6'd13: v = 22'd177337;
         6'd14: v = 22'd120653;
         6'd15: v = 22'd77065;
         6'd16: v = 22'd45426;
         6'd17: v = 22'd24179;
         6'd18: v = 22'd11322;
         6'd19: v = 22'd4531;
         6'd20: v = 22'd1508;
         6'd21: v = 22'd408;
         6'd22: v = 22'd89;
         6'd23: v = 22'd15;
         6'd24: v = 22'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/cnnacc_if.sv =====
interface cnnacc_req_if import cnnacc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       sample_finite;
   logic signed [SAMPLE_W-1:0] lower_bound;
   logic signed [SAMPLE_W-1:0] upper_bound;
   logic                       last_sample;

   modport source(output valid, sample, sample_finite, lower_bound, upper_bound, last_sample,
                  input ready);
   modport sink(input valid, sample, sample_finite, lower_bound, upper_bound, last_sample,
                output ready);
endinterface

interface cnnacc_rsp_if import cnnacc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [NLL_W-1:0] neg_log_lik;
   logic                    saturated;

   modport source(output valid, neg_log_lik, saturated, input ready);
   modport sink(input valid, neg_log_lik, saturated, output ready);
endinterface

interface cnnacc_csr_if import cnnacc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cnnacc_ram.sv =====
module cnnacc_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cnnacc_ctrl.sv =====
module cnnacc_ctrl import cnnacc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = OP_NONE;
      req_ready    = 1'b0;
      emit         = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            cmd.op = OP_FILL;
            if (stat.fill_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (stat.skip) begin
               state_in = ST_DONE;
            end else begin
               cmd.op   = OP_DIFF;
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            cmd.op   = OP_ABS;
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.op   = OP_MUL0;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = ST_ROUTE;
         end
         ST_ROUTE: begin
            unique case (stat.path)
               PATH_UNC, PATH_TAIL: state_in = ST_SQ;
               PATH_TABLE:          state_in = ST_TIDX;
               PATH_SAT:            state_in = ST_SAT;
               default:             state_in = ST_DONE;
            endcase
         end
         ST_SQ: begin
            cmd.op   = OP_SQ;
            cnt_in   = '0;
            state_in = (stat.path == PATH_TAIL) ? ST_DIV : ST_UNC;
         end
         ST_UNC: begin
            cmd.op   = OP_UNC;
            state_in = ST_ACC;
         end
         ST_TIDX: begin
            cmd.op   = OP_TIDX;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            cmd.op   = OP_RD0;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.op   = OP_RD1;
            state_in = ST_CAP1;
         end
         ST_CAP1: begin
            cmd.op   = OP_CAP1;
            state_in = ST_TINT;
         end
         ST_TINT: begin
            cmd.op   = OP_TINT;
            state_in = ST_ACC;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == DIV_STEPS - 5'd1) begin
               cnt_in   = '0;
               state_in = ST_LNNORM;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_LNNORM: begin
            if (stat.ln_norm) begin
               state_in = ST_LNSQ;
            end else begin
               cmd.op = OP_LNNORM;
            end
         end
         ST_LNSQ: begin
            cmd.op = OP_LNSQ;
            if (cnt_ff == LN_STEPS - 5'd1) begin
               cnt_in   = '0;
               state_in = ST_LNMUL;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_LNMUL: begin
            cmd.op   = OP_LNMUL;
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            cmd.op   = OP_TAIL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_DONE;
         end
         ST_SAT: begin
            cmd.op   = OP_SAT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.last) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset) state_ff == ST_DIV |-> cnt_ff < DIV_STEPS)
      else $error("divider step count out of range");
   assert property (@(posedge clock) disable iff (reset) emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule

// ===== hw/rtl/cnnacc_dp.sv =====
module cnnacc_dp import cnnacc_pkg::*; #(
   parameter int PHI_TABLE_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                csr_data,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       sample_finite,
   input  logic signed [SAMPLE_W-1:0] lower_bound,
   input  logic signed [SAMPLE_W-1:0] upper_bound,
   input  logic                       last_sample,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   output logic signed [NLL_W-1:0]    neg_log_lik,
   output logic                       saturated
);

   localparam int ADDR_W = $clog2(PHI_TABLE_DEPTH);
   localparam int FENT_W = TABLE_W + ADDR_W;

   // configuration
   logic [1:0]                 mode_ff, mode_in;
   logic signed [31:0]         mean_ff, mean_in;
   logic signed [31:0]         log_sigma_ff, log_sigma_in;
   logic [31:0]                inv_sigma_ff, inv_sigma_in;
   // table fill
   logic [ADDR_W-1:0]          fill_idx_ff, fill_idx_in;
   // request and standardization
   kind_type                   kind_ff, kind_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                       skip_ff, skip_in;
   logic                       last_ff, last_in;
   logic signed [MAG_W-1:0]    d_ff, d_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [48:0]                pp_ff, pp_in;
   logic [Q_W-1:0]             q_ff, q_in;
   logic [63:0]                sq_ff, sq_in;
   // table lookup
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic [19:0]                fr_ff, fr_in;
   logic                       hi_zero_ff, hi_zero_in;
   logic [TABLE_W-1:0]         t0_ff, t0_in, t1_ff, t1_in;
   // tail
   logic [48:0]                rem_ff, rem_in;
   logic [73:0]                den_ff, den_in;
   logic [10:0]                quot_ff, quot_in;
   logic [31:0]                xl_ff, xl_in;
   logic [4:0]                 e_ff, e_in;
   logic [15:0]                f_ff, f_in;
   logic [19:0]                ln_ff, ln_in;
   // accumulation
   logic signed [TERM_W-1:0]   term_ff, term_in;
   logic signed [NLL_W-1:0]    sum_ff, sum_in;
   logic                       ovf_ff, ovf_in;
   logic signed [NLL_W-1:0]    nll_ff, nll_in;
   logic                       sat_ff, sat_in;

   logic [1:0]                 mode_eff;
   kind_type                   kind_new;
   logic [48:0]                mul_lo, mul_hi;
   logic [64:0]                prod;
   logic [31:0]                sq_a;
   logic [63:0]                sqr;
   logic [32:0]                x2;
   logic                       qsat, pneg;
   path_type                   path;
   logic [20:0]                off;
   logic [ADDR_W-1:0]          idx_new;
   logic [19:0]                fr_new;
   logic [TABLE_W-1:0]         tdiff;
   logic [41:0]                tprod, tip;
   logic [4:0]                 fa;
   logic [ADDR_W-1:0]          fr_fill;
   logic [TABLE_W-1:0]         fa0, fa1, fdiff;
   logic [FENT_W-1:0]          fent;
   logic [4:0]                 e_off;
   logic [35:0]                lnprod;
   logic signed [31:0]         ls16;
   logic signed [TERM_W-1:0]   sq_term, half_term;
   logic signed [50:0]         acc_s;
   logic                       den_le;
   logic [ADDR_W-1:0]          rd_addr;
   logic [TABLE_W-1:0]         rd_data;

   assign mode_eff = (mode_ff == 2'd3) ? MODE_BOTH : mode_ff;

   always_comb begin
      priority if (mode_eff == MODE_LOWER) begin
         kind_new = (sample > lower_bound) ? KIND_UNC : KIND_LOWER;
      end else if (mode_eff == MODE_UPPER) begin
         kind_new = (sample < upper_bound) ? KIND_UNC : KIND_UPPER;
      end else if (sample >= upper_bound) begin
         kind_new = KIND_UPPER;
      end else begin
         kind_new = (sample > lower_bound) ? KIND_UNC : KIND_LOWER;
      end
   end

   assign mul_lo = mag_ff * inv_sigma_ff[15:0];
   assign mul_hi = mag_ff * inv_sigma_ff[31:16];
   assign prod   = {16'd0, pp_ff} + {mul_hi, 16'd0};

   assign sq_a = (cmd.op == OP_LNSQ) ? xl_ff : q_ff[31:0];
   assign sqr  = sq_a * sq_a;
   assign x2   = sqr[63:31];

   assign qsat = |q_ff[Q_W-1:32];
   assign pneg = (kind_ff == KIND_LOWER) ? neg_ff : ~neg_ff;

   always_comb begin
      priority if (kind_ff == KIND_UNC) begin
         path = qsat ? PATH_SAT : PATH_UNC;
      end else if (!pneg) begin
         path = (q_ff >= EIGHT_Q16) ? PATH_ZERO : PATH_TABLE;
      end else if (q_ff > EIGHT_Q16) begin
         path = qsat ? PATH_SAT : PATH_TAIL;
      end else begin
         path = PATH_TABLE;
      end
   end

   assign off     = pneg ? (EIGHT_Q16[20:0] - q_ff[20:0]) : (q_ff[20:0] + EIGHT_Q16[20:0]);
   assign idx_new = off[19 -: ADDR_W];
   assign fr_new  = off[19:0] << ADDR_W;

   assign tdiff = t0_ff - t1_ff;
   assign tprod = tdiff * fr_ff;
   assign tip   = {t0_ff, 20'd0} - tprod;

   assign fa      = fill_idx_ff[ADDR_W-1 -: 5];
   assign fr_fill = {fill_idx_ff[ADDR_W-6:0], 5'd0};
   assign fa0     = phi_anchor({1'b0, fa});
   assign fa1     = phi_anchor({1'b0, fa} + 6'd1);
   assign fdiff   = fa0 - fa1;
   assign fent    = {fa0, {ADDR_W{1'b0}}} - fdiff * fr_fill;

   assign e_off  = e_ff - LN_BIAS;
   assign lnprod = {e_off[3:0], f_ff} * LN2_Q16;

   assign ls16      = log_sigma_ff >>> 8;
   assign sq_term   = $signed({3'd0, sq_ff[63:17]});
   assign half_term = $signed({34'd0, HALF_LOG_2PI});
   assign acc_s     = sum_ff + term_ff;
   assign den_le    = den_ff <= {25'd0, rem_ff};

   always_comb begin
      mode_in      = mode_ff;
      mean_in      = mean_ff;
      log_sigma_in = log_sigma_ff;
      inv_sigma_in = inv_sigma_ff;
      fill_idx_in  = fill_idx_ff;
      kind_in      = kind_ff;
      x_in         = x_ff;
      skip_in      = skip_ff;
      last_in      = last_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      pp_in        = pp_ff;
      q_in         = q_ff;
      sq_in        = sq_ff;
      idx_in       = idx_ff;
      fr_in        = fr_ff;
      hi_zero_in   = hi_zero_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      xl_in        = xl_ff;
      e_in         = e_ff;
      f_in         = f_ff;
      ln_in        = ln_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      nll_in       = nll_ff;
      sat_in       = sat_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CENSOR_MODE: mode_in      = csr_data[1:0];
            CSR_MEAN:        mean_in      = csr_data;
            CSR_LOG_SIGMA:   log_sigma_in = csr_data;
            CSR_INV_SIGMA:   inv_sigma_in = csr_data;
            default:         mode_in      = mode_ff;
         endcase
      end

      unique case (cmd.op)
         OP_FILL: fill_idx_in = fill_idx_ff + 1'b1;
         OP_LOAD: begin
            kind_in = kind_new;
            unique case (kind_new)
               KIND_LOWER: x_in = lower_bound;
               KIND_UPPER: x_in = upper_bound;
               default:    x_in = sample;
            endcase
            skip_in = ~sample_finite | ovf_ff;
            last_in = last_sample;
         end
         OP_DIFF: d_in = {x_ff[31], x_ff} - {mean_ff[31], mean_ff};
         OP_ABS: begin
            neg_in = d_ff[MAG_W-1];
            mag_in = d_ff[MAG_W-1] ? MAG_W'(-d_ff) : MAG_W'(d_ff);
         end
         OP_MUL0: pp_in = mul_lo;
         OP_MUL1: q_in = prod[64:24];
         OP_SQ: begin
            sq_in   = sqr;
            rem_in  = {1'b1, 48'd0};
            den_in  = {sqr, 10'd0};
            quot_in = '0;
            xl_in   = q_ff[31:0];
            e_in    = LN_TOP;
            f_in    = '0;
         end
         OP_UNC: term_in = sq_term + ls16 + half_term;
         OP_TIDX: begin
            idx_in     = idx_new;
            fr_in      = fr_new;
            hi_zero_in = (idx_new == ADDR_W'(PHI_TABLE_DEPTH - 1));
         end
         OP_RD1:  t0_in = rd_data;
         OP_CAP1: t1_in = hi_zero_ff ? '0 : rd_data;
         OP_TINT: term_in = $signed({28'd0, tip[41:20]});
         OP_DIV: begin
            if (den_le) begin
               rem_in  = rem_ff - den_ff[48:0];
               quot_in = {quot_ff[9:0], 1'b1};
            end else begin
               quot_in = {quot_ff[9:0], 1'b0};
            end
            den_in = den_ff >> 1;
         end
         OP_LNNORM: begin
            xl_in = xl_ff << 1;
            e_in  = e_ff - 5'd1;
         end
         OP_LNSQ: begin
            if (x2[32]) begin
               xl_in = x2[32:1];
               f_in  = {f_ff[14:0], 1'b1};
            end else begin
               xl_in = x2[31:0];
               f_in  = {f_ff[14:0], 1'b0};
            end
         end
         OP_LNMUL: ln_in = lnprod[35:16];
         OP_TAIL: term_in = sq_term + $signed({30'd0, ln_ff}) + half_term
                            + $signed({39'd0, quot_ff});
         OP_ACC: begin
            priority if (acc_s > SUM_MAX) begin
               sum_in = SUM_MAX;
               ovf_in = 1'b1;
            end else if (acc_s < SUM_MIN) begin
               sum_in = SUM_MIN;
               ovf_in = 1'b1;
            end else begin
               sum_in = acc_s[NLL_W-1:0];
            end
         end
         OP_SAT: begin
            sum_in = SUM_MAX;
            ovf_in = 1'b1;
         end
         OP_EMIT: begin
            nll_in = sum_ff;
            sat_in = ovf_ff;
            sum_in = '0;
            ovf_in = 1'b0;
         end
         default: term_in = term_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BOTH;
         mean_ff      <= '0;
         log_sigma_ff <= '0;
         inv_sigma_ff <= INV_SIGMA_RESET;
         fill_idx_ff  <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         mean_ff      <= mean_in;
         log_sigma_ff <= log_sigma_in;
         inv_sigma_ff <= inv_sigma_in;
         fill_idx_ff  <= fill_idx_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      x_ff       <= x_in;
      skip_ff    <= skip_in;
      last_ff    <= last_in;
      d_ff       <= d_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      pp_ff      <= pp_in;
      q_ff       <= q_in;
      sq_ff      <= sq_in;
      idx_ff     <= idx_in;
      fr_ff      <= fr_in;
      hi_zero_ff <= hi_zero_in;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      quot_ff    <= quot_in;
      xl_ff      <= xl_in;
      e_ff       <= e_in;
      f_ff       <= f_in;
      ln_ff      <= ln_in;
      term_ff    <= term_in;
      nll_ff     <= nll_in;
      sat_ff     <= sat_in;
   end

   assign rd_addr = (cmd.op == OP_RD1) ? idx_ff + 1'b1 : idx_ff;

   cnnacc_ram #(
      .WIDTH(TABLE_W),
      .DEPTH(PHI_TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (cmd.op == OP_FILL),
      .wr_addr(fill_idx_ff),
      .wr_data(fent[FENT_W-1 -: TABLE_W]),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign stat.skip      = skip_ff;
   assign stat.last      = last_ff;
   assign stat.path      = path;
   assign stat.ln_norm   = xl_ff[31];
   assign stat.fill_last = (fill_idx_ff == ADDR_W'(PHI_TABLE_DEPTH - 1));

   assign neg_log_lik = nll_ff;
   assign saturated   = sat_ff;

   assert property (@(posedge clock) disable iff (reset) cmd.op == OP_LNMUL |-> xl_ff[31])
      else $error("log argument not normalized");
   assert property (@(posedge clock) disable iff (reset)
                    $rose(ovf_ff) |-> (sum_ff == SUM_MAX || sum_ff == SUM_MIN))
      else $error("overflow flagged without clamped sum");

endmodule

// ===== hw/rtl/censored_normal_nll_accumulator_top.sv =====
// Censored normal negative log-likelihood accumulator.
// req_bus: one observation per request (sample, bounds, finite flag, last flag).
// rsp_bus: one result per data set, sent after the request that carries
//   last_sample; it holds the Q32.16 sum and the saturation flag, and the sum
//   then restarts from zero.
// csr_bus: register writes (0 censor mode, 1 mean, 2 log sigma, 3 inv sigma),
//   always ready; write only while no request is in flight.
// After reset the -log Phi table is filled, one entry a cycle, and req_bus.ready
// stays low until the fill ends.
// One request at a time, whether skipped, uncensored, a table lookup (two reads
// through the table's single read port) or the far tail, which runs the 11-step
// divider, normalization and 16 squaring steps of the log unit.
// The result sits in an output register; a stalled receiver holds the block
// only when the next data set's result is ready to leave.
module censored_normal_nll_accumulator_top import cnnacc_pkg::*; #(
   parameter int PHI_TABLE_DEPTH = 1024
) (
   input logic         clock,
   input logic         reset,
   cnnacc_req_if.sink  req_bus,
   cnnacc_rsp_if.source rsp_bus,
   cnnacc_csr_if.sink  csr_bus
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_bus.ready = 1'b1;

   cnnacc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_ready(rsp_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .cmd      (cmd),
      .stat     (stat)
   );

   cnnacc_dp #(
      .PHI_TABLE_DEPTH(PHI_TABLE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_data     (csr_bus.data),
      .sample       (req_bus.sample),
      .sample_finite(req_bus.sample_finite),
      .lower_bound  (req_bus.lower_bound),
      .upper_bound  (req_bus.upper_bound),
      .last_sample  (req_bus.last_sample),
      .cmd          (cmd),
      .stat         (stat),
      .neg_log_lik  (rsp_bus.neg_log_lik),
      .saturated    (rsp_bus.saturated)
   );

endmodule
